/* rtl/ddmd_pkg.sv */
package ddmd_pkg;

    localparam int PIXEL_COUNT = 25;
    localparam int GLYPHS      = 10;
    localparam int ROWS        = 5;
    localparam int COLS        = 5;

    localparam logic [1:0] MODE_REFRESH   = 2'd0;
    localparam logic [1:0] MODE_DECREMENT = 2'd1;
    localparam logic [1:0] MODE_INCREMENT = 2'd2;

    localparam logic [1:0] REG_RED     = 2'd0;
    localparam logic [1:0] REG_GREEN   = 2'd1;
    localparam logic [1:0] REG_BLUE    = 2'd2;
    localparam logic [1:0] REG_LOCKOUT = 2'd3;

    localparam logic [7:0]  RED_RESET     = 8'd0;
    localparam logic [7:0]  GREEN_RESET   = 8'd0;
    localparam logic [7:0]  BLUE_RESET    = 8'd20;
    localparam logic [31:0] LOCKOUT_RESET = 32'd250000;

    localparam logic [2:0] ROW_FIRST = 3'(ROWS - 1);
    localparam logic [2:0] COL_LAST  = 3'(COLS - 1);

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic   valid;
        digit_t digit;
    } frame_req_t;

    localparam logic [4:0] FONT_ROWS [GLYPHS][ROWS] = '{
        '{5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04},
        '{5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E},
        '{5'h0E, 5'h02, 5'h0E, 5'h02, 5'h0E},
        '{5'h0A, 5'h0A, 5'h0E, 5'h02, 5'h02},
        '{5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E},
        '{5'h0E, 5'h08, 5'h0E, 5'h0A, 5'h0E},
        '{5'h0E, 5'h02, 5'h02, 5'h02, 5'h02},
        '{5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E},
        '{5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h0E}
    };

    function automatic logic glyph_bit(digit_t digit, logic [2:0] row, logic [2:0] col);
        logic [4:0] bits;
        logic       lit;
        lit = 1'b0;
        if (digit < 4'(GLYPHS) && row < 3'(ROWS) && col < 3'(COLS))
        begin
            bits = FONT_ROWS[digit][row];
            lit  = bits[COL_LAST - col];
        end
        return lit;
    endfunction

endpackage

/* rtl/debounced_digit_matrix_display.sv */
// An item that emits a frame waits in the pending register until ddmd_frame_gen
// takes it; the frame leaves its output register as 25 pixel words from the
// row/column scan, one pixel word per cycle while m_tready is high. An item that
// emits nothing gives no frame; one further emitting item waits while a frame is sent.
// Reset: rst_n is asynchronous, active low; digit 0, last press time 0, default levels.
module debounced_digit_matrix_display
#(
    parameter int DIGIT_COUNT = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // time_us[31:0]
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // pixel_color[23:0]
    output logic        m_tlast
);

    localparam ddmd_pkg::digit_t LAST_DIGIT = 4'(DIGIT_COUNT - 1);

    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic [31:0] lockout_reg, lockout_next;

    ddmd_pkg::digit_t digit_reg, digit_next;
    logic [31:0]      time_reg, time_next;
    logic             pend_valid_reg, pend_valid_next;
    ddmd_pkg::digit_t pend_digit_reg, pend_digit_next;

    logic             cfg_write;
    logic [1:0]       reg_index;
    logic             in_accept;
    logic             is_press;
    logic             press_ok;
    logic [31:0]      elapsed;
    ddmd_pkg::digit_t stepped;
    logic             req_take;
    ddmd_pkg::frame_req_t req;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_index)
            ddmd_pkg::REG_RED:     prdata = {24'd0, red_reg};
            ddmd_pkg::REG_GREEN:   prdata = {24'd0, green_reg};
            ddmd_pkg::REG_BLUE:    prdata = {24'd0, blue_reg};
            ddmd_pkg::REG_LOCKOUT: prdata = lockout_reg;
            default:               prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        lockout_next = lockout_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                ddmd_pkg::REG_RED:     red_next     = pwdata[7:0];
                ddmd_pkg::REG_GREEN:   green_next   = pwdata[7:0];
                ddmd_pkg::REG_BLUE:    blue_next    = pwdata[7:0];
                ddmd_pkg::REG_LOCKOUT: lockout_next = pwdata;
                default:               lockout_next = lockout_reg;
            endcase
        end
    end

    assign s_tready  = !pend_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign is_press  = (s_tuser == ddmd_pkg::MODE_DECREMENT) ||
                       (s_tuser == ddmd_pkg::MODE_INCREMENT);
    assign elapsed   = s_tdata - time_reg;
    assign press_ok  = is_press && (elapsed > lockout_reg);

    always_comb
    begin
        if (s_tuser == ddmd_pkg::MODE_INCREMENT)
        begin
            stepped = (digit_reg >= LAST_DIGIT) ? 4'd0 : digit_reg + 4'd1;
        end
        else
        begin
            stepped = (digit_reg == 4'd0 || digit_reg > LAST_DIGIT) ? LAST_DIGIT
                                                                    : digit_reg - 4'd1;
        end
    end

    always_comb
    begin
        digit_next      = digit_reg;
        time_next       = time_reg;
        pend_valid_next = pend_valid_reg;
        pend_digit_next = pend_digit_reg;

        if (req_take)
        begin
            pend_valid_next = 1'b0;
        end

        if (in_accept)
        begin
            if (press_ok)
            begin
                digit_next      = stepped;
                time_next       = s_tdata;
                pend_valid_next = 1'b1;
                pend_digit_next = stepped;
            end
            else if (s_tuser == ddmd_pkg::MODE_REFRESH)
            begin
                pend_valid_next = 1'b1;
                pend_digit_next = digit_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg        <= ddmd_pkg::RED_RESET;
            green_reg      <= ddmd_pkg::GREEN_RESET;
            blue_reg       <= ddmd_pkg::BLUE_RESET;
            lockout_reg    <= ddmd_pkg::LOCKOUT_RESET;
            digit_reg      <= 4'd0;
            time_reg       <= 32'd0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            red_reg        <= red_next;
            green_reg      <= green_next;
            blue_reg       <= blue_next;
            lockout_reg    <= lockout_next;
            digit_reg      <= digit_next;
            time_reg       <= time_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_digit_reg <= pend_digit_next;
    end

    assign req.valid = pend_valid_reg;
    assign req.digit = pend_digit_reg;

    ddmd_frame_gen u_frame_gen
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .req_take (req_take),
        .color    ({green_reg, red_reg, blue_reg}),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/ddmd_frame_gen.sv */
module ddmd_frame_gen
(
    input  logic                clk,
    input  logic                rst_n,
    input  ddmd_pkg::frame_req_t req,
    output logic                req_take,
    input  logic [23:0]         color,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,  // pixel_color[23:0]
    output logic                m_tlast
);

    logic            busy_reg, busy_next;
    ddmd_pkg::digit_t digit_reg, digit_next;
    logic [2:0]      row_reg, row_next;
    logic [2:0]      col_reg, col_next;
    logic            valid_reg, valid_next;
    logic [23:0]     data_reg, data_next;
    logic            last_reg, last_next;

    logic out_load;
    logic at_end;

    assign out_load = busy_reg && (!valid_reg || m_tready);
    assign at_end   = (row_reg == 3'd0) && (col_reg == 3'd0);
    assign req_take = !busy_reg || (out_load && at_end);

    always_comb
    begin
        busy_next  = busy_reg;
        digit_next = digit_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;

        if (m_tready)
        begin
            valid_next = 1'b0;
        end

        if (out_load)
        begin
            valid_next = 1'b1;
            data_next  = ddmd_pkg::glyph_bit(digit_reg, row_reg, col_reg) ? color : 24'd0;
            last_next  = at_end;
            if (!row_reg[0])
            begin
                if (col_reg == 3'd0)
                begin
                    row_next = row_reg - 3'd1;
                end
                else
                begin
                    col_next = col_reg - 3'd1;
                end
            end
            else
            begin
                if (col_reg == ddmd_pkg::COL_LAST)
                begin
                    row_next = row_reg - 3'd1;
                end
                else
                begin
                    col_next = col_reg + 3'd1;
                end
            end
            if (at_end)
            begin
                busy_next = 1'b0;
            end
        end

        if (req_take && req.valid)
        begin
            busy_next  = 1'b1;
            digit_next = req.digit;
            row_next   = ddmd_pkg::ROW_FIRST;
            col_next   = ddmd_pkg::COL_LAST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        data_reg  <= data_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

/* bench/tb_debounced_digit_matrix_display.sv */
module tb_debounced_digit_matrix_display;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         DIGITS       = 10;
    localparam int         SETTLE_WAIT  = 6;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         REPORT_LIMIT = 10;

    class digit_frame_scoreboard;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] lockout;
        logic [3:0]  digit;
        logic [31:0] last_press;
        logic [24:0] expected_pixels[$];
        int          mismatches;

        function new();
            red        = ddmd_pkg::RED_RESET;
            green      = ddmd_pkg::GREEN_RESET;
            blue       = ddmd_pkg::BLUE_RESET;
            lockout    = ddmd_pkg::LOCKOUT_RESET;
            digit      = '0;
            last_press = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                ddmd_pkg::REG_RED:     red     = value[7:0];
                ddmd_pkg::REG_GREEN:   green   = value[7:0];
                ddmd_pkg::REG_BLUE:    blue    = value[7:0];
                ddmd_pkg::REG_LOCKOUT: lockout = value;
                default:     ;
            endcase
        endfunction

        // rows top to bottom, bit 4 of each row is the left column
        function logic [24:0] glyph(logic [3:0] d);
            case (d)
                4'd0:    return {5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E};
                4'd1:    return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04};
                4'd2:    return {5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E};
                4'd3:    return {5'h0E, 5'h02, 5'h0E, 5'h02, 5'h0E};
                4'd4:    return {5'h0A, 5'h0A, 5'h0E, 5'h02, 5'h02};
                4'd5:    return {5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E};
                4'd6:    return {5'h0E, 5'h08, 5'h0E, 5'h0A, 5'h0E};
                4'd7:    return {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02};
                4'd8:    return {5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E};
                4'd9:    return {5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h0E};
                default: return '0;
            endcase
        endfunction

        function void queue_frame();
            logic [24:0] shape;
            logic [23:0] color;
            logic        frame_end;
            int          font_cell;
            shape = glyph(digit);
            color = {green, red, blue};
            for (int i = 0; i < ddmd_pkg::PIXEL_COUNT; i++)
            begin
                if (i >= 5 && i < 10)
                    font_cell = i + 10;
                else if (i >= 15 && i < 20)
                    font_cell = i - 10;
                else
                    font_cell = ddmd_pkg::PIXEL_COUNT - 1 - i;
                frame_end = (i == ddmd_pkg::PIXEL_COUNT - 1);
                expected_pixels.push_back({frame_end, shape[24 - font_cell] ? color : 24'h0});
            end
        endfunction

        function void take_item(logic [1:0] mode, logic [31:0] stamp);
            logic [31:0] since;
            since = stamp - last_press;
            if (mode == ddmd_pkg::MODE_REFRESH)
                queue_frame();
            else if ((mode == ddmd_pkg::MODE_INCREMENT || mode == ddmd_pkg::MODE_DECREMENT)
                     && since > lockout)
            begin
                last_press = stamp;
                if (mode == ddmd_pkg::MODE_INCREMENT)
                    digit = (digit >= DIGITS - 1) ? 4'd0 : digit + 4'd1;
                else
                    digit = (digit == 0 || digit >= DIGITS) ? 4'(DIGITS - 1) : digit - 4'd1;
                queue_frame();
            end
        endfunction

        function void flag(string what, logic [24:0] want, logic [24:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t %s: expected color %06h last %b, got color %06h last %b",
                         $time, what, want[23:0], want[24], got[23:0], got[24]);
        endfunction

        function void check_pixel(logic [23:0] color, logic frame_end);
            logic [24:0] want;
            if (expected_pixels.size() == 0)
            begin
                flag("unexpected word", 'x, {frame_end, color});
                return;
            end
            want = expected_pixels.pop_front();
            if (want[23:0] !== color || want[24] !== frame_end)
                flag("word mismatch", want, {frame_end, color});
        endfunction

        function int outstanding();
            return expected_pixels.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // time_us[31:0]
    logic [1:0]  s_tuser  = '0;  // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // pixel_color[23:0]
    logic        m_tlast;

    digit_frame_scoreboard sb;
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;
    int          stall_left  = 0;
    int unsigned cycle_count = 0;

    debounced_digit_matrix_display uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left = pick_gap(rx_calm);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [31:0] stamp);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= stamp;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_item(mode, stamp);
    endtask

    // drop valid, then hold until every expected word is out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic set_levels(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b, input logic [31:0] lock);
        wait_idle();
        write_reg(ddmd_pkg::REG_RED, r);
        write_reg(ddmd_pkg::REG_GREEN, g);
        write_reg(ddmd_pkg::REG_BLUE, b);
        write_reg(ddmd_pkg::REG_LOCKOUT, lock);
    endtask

    task automatic run_presses(input int count);
        int          sent;
        int          r;
        int          pick;
        logic [1:0]  mode;
        logic [31:0] advance;
        logic [31:0] stamp;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                wait_idle();
            if (r >= 95)
                send_item(MODE_UNUSED, $urandom);
            else
            begin
                if (r < 22)
                    mode = ddmd_pkg::MODE_REFRESH;
                else if (r < 60)
                    mode = ddmd_pkg::MODE_INCREMENT;
                else
                    mode = ddmd_pkg::MODE_DECREMENT;
                pick = $urandom_range(0, 99);
                if (mode == ddmd_pkg::MODE_REFRESH)
                    advance = $urandom;
                else if (pick < 70)
                    advance = sb.lockout + 32'd1 + $urandom_range(0, 5000);
                else if (pick < 78)
                    advance = sb.lockout;
                else if (pick < 90)
                    advance = $urandom_range(0, sb.lockout);
                else
                    advance = $urandom;
                stamp = (mode == ddmd_pkg::MODE_REFRESH) ? advance : sb.last_press + advance;
                send_item(mode, stamp);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        send_item(ddmd_pkg::MODE_REFRESH, 32'd0);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF);
        send_item(ddmd_pkg::MODE_INCREMENT, 32'd250000);
        send_item(ddmd_pkg::MODE_INCREMENT, 32'd250001);
        send_item(ddmd_pkg::MODE_DECREMENT, 32'd500001);
        send_item(ddmd_pkg::MODE_DECREMENT, 32'd500002);
        send_item(ddmd_pkg::MODE_DECREMENT, 32'd750003);
        send_item(ddmd_pkg::MODE_INCREMENT, 32'd1000004);
        send_item(ddmd_pkg::MODE_INCREMENT, 32'd1000104);
        send_item(ddmd_pkg::MODE_REFRESH, 32'h5A5A_A5A5);
        send_item(ddmd_pkg::MODE_INCREMENT, 32'hFFFF_0000);
        send_item(ddmd_pkg::MODE_DECREMENT, 32'h0004_0000);
        send_item(ddmd_pkg::MODE_DECREMENT, 32'h0004_0001);

        set_levels(32'hFF, 32'hFF, 32'hFF, 32'd0);
        send_item(ddmd_pkg::MODE_INCREMENT, 32'h0004_0000);
        send_item(ddmd_pkg::MODE_INCREMENT, 32'h0004_0001);
        send_item(MODE_UNUSED, 32'd0);
        send_item(ddmd_pkg::MODE_REFRESH, 32'hFFFF_FFFF);

        set_levels(32'h0, 32'hA5, 32'h0, 32'hFFFF_FFFF);
        send_item(ddmd_pkg::MODE_INCREMENT, 32'h8000_0000);
        send_item(ddmd_pkg::MODE_DECREMENT, 32'h0004_0000);
        send_item(ddmd_pkg::MODE_REFRESH, 32'd0);

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        set_levels($urandom, $urandom, $urandom, $urandom_range(0, 1000));
        run_presses(22);

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        set_levels(32'hFF, 32'h00, 32'h80, ddmd_pkg::LOCKOUT_RESET);
        run_presses(22);

        tx_calm = 1'b1;
        rx_calm = 1'b0;
        set_levels($urandom, $urandom, $urandom, $urandom_range(100000, 300000));
        run_presses(22);

        tx_calm = 1'b0;
        rx_calm = 1'b1;
        set_levels($urandom, $urandom, $urandom, $urandom);
        run_presses(22);

        wait_idle();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
